// File: rtl/core/masq_pkg.sv
// ----------------------------------------------------------------------------
// masq_pkg
// Types, register indexes, reset values and drive tables shared by the
// microstep axis sequencer.
// ----------------------------------------------------------------------------
package masq_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_RES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSTSCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BL_FAST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDEREAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PER   = 3'd5;

  localparam logic [30:0] RST_ENC_RES   = 31'd25559088;
  localparam logic [6:0]  RST_POSTSCALE = 7'd1;
  localparam logic [15:0] RST_BACKLASH  = 16'd2;
  localparam logic        RST_BL_FAST   = 1'b1;
  localparam logic [15:0] RST_SIDEREAL  = 16'd40960;
  localparam logic [15:0] RST_FAST_PER  = 16'd65286;

  localparam logic [3:0] WAVE_MAX_IDX = 4'd10;
  localparam logic [7:0] DUTY_FULL    = 8'hFF;

  typedef struct packed {
    logic [30:0] enc_res;
    logic [6:0]  postscale;
    logic [15:0] backlash_steps;
    logic        bl_fast_en;
    logic [15:0] sidereal_period;
    logic [15:0] fast_period;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic        index_seen;
    logic [1:0]  direction;
    logic [15:0] step_period;
    logic        full_step;
    logic        goto_enable;
    logic [30:0] goto_target;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  coil_pattern_a;
    logic [7:0]  coil_pattern_b;
    logic [7:0]  pwm_duty;
    logic [7:0]  pwm_complement;
    logic [30:0] position;
    logic [15:0] reload_period;
    logic        reload_absolute;
    logic        goto_reached;
    logic        index_captured;
    logic [30:0] index_position;
    logic        step_taken;
    logic [7:0]  full_step_pattern;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  postscale_count;
    logic [15:0] backlash_count;
    logic [30:0] position;
    logic [2:0]  phase;
    logic [7:0]  pat_pri;
    logic [7:0]  pat_sec;
    logic [1:0]  dir;
    logic [15:0] period;
    logic        goto_armed;
    logic        full_step_mode;
    logic [30:0] captured;
    logic [30:0] goto_pos;
  } axis_state_t;

  function automatic logic [7:0] wave_value(input logic [3:0] k);
    logic [7:0] v;
    case (k)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd38;
      4'd2:    v = 8'd76;
      4'd3:    v = 8'd102;
      4'd4:    v = 8'd127;
      4'd5:    v = 8'd153;
      4'd6:    v = 8'd178;
      4'd7:    v = 8'd191;
      4'd8:    v = 8'd220;
      4'd9:    v = 8'd235;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] coil_value(input logic [2:0] p);
    logic [7:0] v;
    case (p)
      3'd0:    v = 8'hf1;
      3'd1:    v = 8'hf3;
      3'd2:    v = 8'hf2;
      3'd3:    v = 8'hf6;
      3'd4:    v = 8'hf4;
      3'd5:    v = 8'hfc;
      3'd6:    v = 8'hf8;
      default: v = 8'hf9;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/masq_cfg_regs.sv
// ----------------------------------------------------------------------------
// masq_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module masq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [masq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [30:0]                      cfg_data,
  output masq_pkg::cfg_t                   cfg
);
  import masq_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enc_res         <= RST_ENC_RES;
      cfg_r.postscale       <= RST_POSTSCALE;
      cfg_r.backlash_steps  <= RST_BACKLASH;
      cfg_r.bl_fast_en      <= RST_BL_FAST;
      cfg_r.sidereal_period <= RST_SIDEREAL;
      cfg_r.fast_period     <= RST_FAST_PER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENC_RES:   cfg_r.enc_res         <= cfg_data;
        CFG_POSTSCALE: cfg_r.postscale       <= cfg_data[6:0];
        CFG_BACKLASH:  cfg_r.backlash_steps  <= cfg_data[15:0];
        CFG_BL_FAST:   cfg_r.bl_fast_en      <= cfg_data[0];
        CFG_SIDEREAL:  cfg_r.sidereal_period <= cfg_data[15:0];
        CFG_FAST_PER:  cfg_r.fast_period     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/masq_step_logic.sv
// ----------------------------------------------------------------------------
// masq_step_logic
// Next-state and result logic for one request: command load, index capture,
// postscaler, backlash take-up, position wrap, microstep advance, goto arrival and PWM lookup.
// ----------------------------------------------------------------------------
module masq_step_logic #(
  parameter int MICROSTEPS = 20,
  parameter int IDXW       = $clog2(MICROSTEPS)
) (
  input  masq_pkg::cfg_t        cfg,
  input  masq_pkg::in_item_t    item,
  input  masq_pkg::axis_state_t st,
  input  logic [IDXW-1:0]       idx,
  output masq_pkg::axis_state_t st_nxt,
  output logic [IDXW-1:0]       idx_nxt,
  output masq_pkg::out_item_t   res
);
  import masq_pkg::*;

  localparam int MIRW = IDXW + 4;
  localparam logic [IDXW-1:0] LAST = IDXW'(MICROSTEPS - 1);
  localparam logic [IDXW-1:0] HALF = IDXW'(MICROSTEPS / 2);
  localparam logic [IDXW-1:0] MID  = IDXW'(MICROSTEPS / 2 - 1);

  axis_state_t     s;
  logic [IDXW-1:0] idx_n;
  logic            fwd;
  logic            took_up;
  logic            wrap;
  logic [6:0]      ps_dec;
  logic [31:0]     pos_inc;
  logic [IDXW:0]   idx_inc;
  logic [MIRW-1:0] mirror;
  logic [3:0]      wave_k;
  logic [7:0]      duty;
  logic [15:0]     reload;
  logic            absolute;
  logic            reached;
  logic            captured;
  logic            stepped;

  always_comb begin
    s        = st;
    idx_n    = idx;
    fwd      = (st.dir == DIR_FWD);
    ps_dec   = st.postscale_count - 7'd1;
    pos_inc  = {1'b0, st.position} + 32'd1;
    idx_inc  = {1'b0, idx} + {{IDXW{1'b0}}, 1'b1};
    took_up  = 1'b0;
    wrap     = 1'b0;
    reload   = 16'd0;
    absolute = 1'b0;
    reached  = 1'b0;
    captured = 1'b0;
    stepped  = 1'b0;
    if (item.operation == OP_CMD) begin
      s.dir            = item.direction;
      s.period         = item.step_period;
      s.full_step_mode = item.full_step;
      s.goto_armed     = item.goto_enable;
      s.goto_pos       = item.goto_target;
    end else if (st.dir != DIR_STOP) begin
      reload = st.period;
      if (item.index_seen && fwd) begin
        captured   = 1'b1;
        s.captured = st.position;
      end
      s.postscale_count = ps_dec;
      if (ps_dec == 7'd0) begin
        s.postscale_count = cfg.postscale;
        stepped           = 1'b1;
        if (fwd) begin
          if (st.backlash_count == 16'd0) begin
            s.position = (pos_inc >= {1'b0, cfg.enc_res}) ? 31'd0 : pos_inc[30:0];
          end else begin
            s.backlash_count = st.backlash_count - 16'd1;
            took_up          = 1'b1;
          end
        end else begin
          if (st.backlash_count == cfg.backlash_steps) begin
            if (st.position == 31'd0) begin
              s.position = (cfg.enc_res == 31'd0) ? 31'd0 : cfg.enc_res - 31'd1;
            end else begin
              s.position = st.position - 31'd1;
            end
          end else begin
            s.backlash_count = st.backlash_count + 16'd1;
            took_up          = 1'b1;
          end
        end
        if (took_up && cfg.bl_fast_en && !st.full_step_mode) begin
          reload            = cfg.fast_period;
          absolute          = 1'b1;
          s.postscale_count = 7'd1;
        end
        if (fwd) begin
          if (idx_inc >= (IDXW+1)'(MICROSTEPS)) begin
            idx_n     = '0;
            s.phase   = st.phase + 3'd2;
            s.pat_pri = coil_value(s.phase + 3'd1);
            s.pat_sec = coil_value(s.phase);
            wrap      = 1'b1;
          end else begin
            idx_n = idx_inc[IDXW-1:0];
          end
        end else begin
          if (idx == '0) begin
            idx_n     = LAST;
            s.phase   = st.phase - 3'd2;
            s.pat_pri = coil_value(s.phase + 3'd1);
            s.pat_sec = coil_value(s.phase + 3'd2);
            wrap      = 1'b1;
          end else begin
            idx_n = idx - {{(IDXW-1){1'b0}}, 1'b1};
          end
        end
        if (!wrap) begin
          if (idx_n == HALF) begin
            s.pat_sec = coil_value(st.phase + 3'd2);
          end else if (idx_n == MID) begin
            s.pat_sec = coil_value(st.phase);
          end
        end
        if (st.goto_armed && (st.goto_pos == s.position)) begin
          reached          = 1'b1;
          s.goto_armed     = 1'b0;
          s.period         = cfg.sidereal_period;
          s.dir            = (cfg.sidereal_period == 16'd0) ? DIR_STOP : DIR_FWD;
          s.full_step_mode = 1'b0;
        end
      end
    end

    mirror = (idx_n > HALF) ? (MIRW'(MICROSTEPS) - MIRW'(idx_n)) : MIRW'(idx_n);
    wave_k = (mirror > MIRW'(WAVE_MAX_IDX)) ? WAVE_MAX_IDX : mirror[3:0];
    duty   = wave_value(wave_k);

    res.coil_pattern_a    = s.pat_pri;
    res.coil_pattern_b    = s.pat_sec;
    res.pwm_duty          = duty;
    res.pwm_complement    = DUTY_FULL - duty;
    res.position          = s.position;
    res.reload_period     = reload;
    res.reload_absolute   = absolute;
    res.goto_reached      = reached;
    res.index_captured    = captured;
    res.index_position    = s.captured;
    res.step_taken        = stepped;
    res.full_step_pattern = s.full_step_mode ? ((idx_n < HALF) ? s.pat_pri : s.pat_sec)
                                             : 8'h00;
    st_nxt  = s;
    idx_nxt = idx_n;
  end

endmodule

// File: rtl/core/microstep_axis_sequencer_unit.sv
// ----------------------------------------------------------------------------
// microstep_axis_sequencer_unit
// Microstep sequencer for one mount axis: ticks and motion commands in,
// coil patterns, PWM duty, position and timer reload out.
// ----------------------------------------------------------------------------
// Usage:
// Each input request is either a period tick or a motion command. The block
// registers it in the input register, computes the axis state update from it
// combinationally and places exactly one result request in the output
// register, where the result holds until the receiver takes it. Throughput is
// one request per cycle while the receiver does not stall, set by the
// combinational state update between the input and output registers.
// The configuration channel is always ready and writes one register per
// request; write it only while no request is in flight.
// Reset (synchronous, active low) empties both registers, loads the default
// configuration and puts the axis at position zero moving forward at the
// sidereal period. When the receiver stalls, the result holds; the input
// register keeps taking one more request, then the input stalls too.
// ----------------------------------------------------------------------------
module microstep_axis_sequencer_unit #(
  parameter int MICROSTEPS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic                           in_index_seen,
  input  logic signed [1:0]              in_direction,
  input  logic [15:0]                    in_step_period,
  input  logic                           in_full_step,
  input  logic                           in_goto_enable,
  input  logic [30:0]                    in_goto_target,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_coil_pattern_a,
  output logic [7:0]                     out_coil_pattern_b,
  output logic [7:0]                     out_pwm_duty,
  output logic [7:0]                     out_pwm_complement,
  output logic [30:0]                    out_position,
  output logic [15:0]                    out_reload_period,
  output logic                           out_reload_absolute,
  output logic                           out_goto_reached,
  output logic                           out_index_captured,
  output logic [30:0]                    out_index_position,
  output logic                           out_step_taken,
  output logic [7:0]                     out_full_step_pattern,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [masq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [30:0]                    cfg_data
);
  import masq_pkg::*;

  localparam int IDXW = $clog2(MICROSTEPS);

  cfg_t            cfg;
  in_item_t        a_item_r;
  logic            a_valid_r;
  axis_state_t     st_r;
  axis_state_t     st_nxt;
  logic [IDXW-1:0] idx_r;
  logic [IDXW-1:0] idx_nxt;
  out_item_t       res_nxt;
  out_item_t       out_item_r;
  logic            out_valid_r;
  logic            out_free;
  logic            fire;

  masq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  masq_step_logic #(
    .MICROSTEPS (MICROSTEPS),
    .IDXW       (IDXW)
  ) u_step (
    .cfg     (cfg),
    .item    (a_item_r),
    .st      (st_r),
    .idx     (idx_r),
    .st_nxt  (st_nxt),
    .idx_nxt (idx_nxt),
    .res     (res_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = a_valid_r && out_free;
  assign in_stall = a_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r            <= 1'b0;
      out_valid_r          <= 1'b0;
      idx_r                <= '0;
      st_r.postscale_count <= 7'd1;
      st_r.backlash_count  <= 16'd0;
      st_r.position        <= 31'd0;
      st_r.phase           <= 3'd0;
      st_r.pat_pri         <= 8'd0;
      st_r.pat_sec         <= 8'd0;
      st_r.dir             <= DIR_FWD;
      st_r.period          <= RST_SIDEREAL;
      st_r.goto_armed      <= 1'b0;
      st_r.full_step_mode  <= 1'b0;
      st_r.captured        <= 31'd0;
      st_r.goto_pos        <= 31'd0;
    end else begin
      if (!in_stall) begin
        a_valid_r            <= in_valid;
        a_item_r.operation   <= in_operation;
        a_item_r.index_seen  <= in_index_seen;
        a_item_r.direction   <= in_direction;
        a_item_r.step_period <= in_step_period;
        a_item_r.full_step   <= in_full_step;
        a_item_r.goto_enable <= in_goto_enable;
        a_item_r.goto_target <= in_goto_target;
      end
      if (out_free) begin
        out_valid_r <= a_valid_r;
      end
      if (fire) begin
        out_item_r <= res_nxt;
        st_r       <= st_nxt;
        idx_r      <= idx_nxt;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_coil_pattern_a    = out_item_r.coil_pattern_a;
  assign out_coil_pattern_b    = out_item_r.coil_pattern_b;
  assign out_pwm_duty          = out_item_r.pwm_duty;
  assign out_pwm_complement    = out_item_r.pwm_complement;
  assign out_position          = out_item_r.position;
  assign out_reload_period     = out_item_r.reload_period;
  assign out_reload_absolute   = out_item_r.reload_absolute;
  assign out_goto_reached      = out_item_r.goto_reached;
  assign out_index_captured    = out_item_r.index_captured;
  assign out_index_position    = out_item_r.index_position;
  assign out_step_taken        = out_item_r.step_taken;
  assign out_full_step_pattern = out_item_r.full_step_pattern;

endmodule

// File: rtl/core/masq_checker.sv
// ----------------------------------------------------------------------------
// masq_checker
// Port-level checks for the microstep axis sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module masq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_pwm_duty,
  input logic [7:0]  out_pwm_complement,
  input logic [30:0] out_position,
  input logic        out_reload_absolute,
  input logic        out_goto_reached,
  input logic        out_step_taken
);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position))
    else $error("Stalled result request changed.");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result request valid after reset.");

  a_duty_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pwm_complement == ~out_pwm_duty)
    else $error("PWM complement does not match duty.");

  a_abs_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reload_absolute |-> out_step_taken)
    else $error("Absolute reload without a microstep.");

  a_goto_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goto_reached |-> out_step_taken)
    else $error("Goto arrival without a microstep.");

endmodule

bind microstep_axis_sequencer_unit masq_checker u_masq_checker (.*);
